[rtl/tsf_pkg.sv]
// Shared constants, types and weight table for the temporal scan filter.
`timescale 1ns / 1ps
`default_nettype none
package tsf_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_WINDOW_DEF  = 7;
    localparam int MAX_POINTS_DEF  = 512;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed port widths
    localparam int SAMPLE_WIDTH   = 16;
    localparam int IDX_BITS       = 9;
    localparam int OUT_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;
    localparam int MODE_BITS      = 2;
    localparam int WLEN_CFG_BITS  = 3;
    localparam int PC_BITS        = 10;

    // Internal widths that cover the whole parameter range
    localparam int WLEN_BITS = 4;   // effective window, up to 15
    localparam int CNT_BITS  = 5;   // step counter, up to 31
    localparam int WT_BITS   = 16;  // one Q1.15 weight
    localparam int WSUM_BITS = 17;  // sum of all weights of a window

    // Register reset values
    localparam logic [WLEN_CFG_BITS-1:0] WINDOW_LENGTH_RST = 3'd1;
    localparam logic [PC_BITS-1:0]       POINT_COUNT_RST   = 10'd401;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_COUNT   = 2'd2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PASS   = 2'd0,
        MODE_GAUSS  = 2'd1,
        MODE_MEAN   = 2'd2,
        MODE_MEDIAN = 2'd3
    } filter_mode_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_WRITE,
        OP_READ,
        OP_ACCUM,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_SORT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [CNT_BITS-1:0] cnt;
    } tsf_cmd_t;

    typedef struct packed {
        logic                 clr_last;
        logic                 pass;
        logic                 median;
        logic [WLEN_BITS-1:0] w_eff;
        logic                 out_free;
    } tsf_status_t;

    // round(32768 * exp(-d*d/4.5)) for d = 0..7
    localparam logic [WT_BITS-1:0] GAUSS_Q15 [8] = '{
        16'd32768, 16'd26239, 16'd13471, 16'd4435,
        16'd936,   16'd127,   16'd11,    16'd1
    };

    function automatic logic [WT_BITS-1:0] gauss_weight(input logic [2:0] wt_dist);
        return GAUSS_Q15[wt_dist];
    endfunction

endpackage
`default_nettype wire

[rtl/tsf_ctrl.sv]
// Controller state machine of the temporal scan filter.
`timescale 1ns / 1ps
`default_nettype none
module tsf_ctrl #(
    parameter int MAX_WINDOW  = tsf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsf_pkg::tsf_status_t status,
    output tsf_pkg::tsf_cmd_t    cmd
);
    import tsf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_SORT,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                last_win;

    assign last_win = (cnt_reg == CNT_BITS'(status.w_eff - WLEN_BITS'(1)));

    // Sequence one transaction through the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (status.clr_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    cnt_reg   <= '0;
                    state_reg <= status.pass ? ST_FINISH : ST_READ;
                end
                ST_READ: begin
                    if (last_win) begin
                        cnt_reg   <= '0;
                        state_reg <= status.median ? ST_SORT : ST_ACCUM;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                end
                ST_ACCUM: begin
                    if (last_win) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVIDE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                end
                ST_DIVIDE: begin
                    if (cnt_reg == CNT_BITS'(SAMPLE_BITS)) state_reg <= ST_FINISH;
                    else cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
                ST_SORT: begin
                    if (cnt_reg == CNT_BITS'(MAX_WINDOW - 1)) state_reg <= ST_FINISH;
                    else cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
                ST_FINISH: begin
                    if (status.out_free) state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Decode state into a datapath operation
    always_comb begin
        cmd.cnt = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:  cmd.op = OP_CLEAR;
            ST_IDLE:   cmd.op = s_valid ? OP_ACCEPT : OP_NONE;
            ST_WRITE:  cmd.op = OP_WRITE;
            ST_READ:   cmd.op = OP_READ;
            ST_ACCUM:  cmd.op = OP_ACCUM;
            ST_DIVIDE: cmd.op = (cnt_reg == '0) ? OP_DIV_LOAD : OP_DIV_STEP;
            ST_SORT:   cmd.op = OP_SORT;
            ST_FINISH: cmd.op = status.out_free ? OP_OUT : OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/tsf_datapath.sv]
// Datapath of the temporal scan filter: registers, history memory, accumulate, divide, sort.
`timescale 1ns / 1ps
`default_nettype none
module tsf_datapath #(
    parameter int MAX_WINDOW  = tsf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_POINTS  = tsf_pkg::MAX_POINTS_DEF,   // power of two
    parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [tsf_pkg::SAMPLE_WIDTH-1:0]      s_sample,
    input  logic [tsf_pkg::IDX_BITS-1:0]          s_point_index,
    input  logic                                  cfg_valid,
    input  logic [tsf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tsf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [tsf_pkg::OUT_BITS-1:0]          m_filtered_value,
    output logic [tsf_pkg::IDX_BITS-1:0]          m_point_out,
    input  tsf_pkg::tsf_cmd_t                     cmd,
    output tsf_pkg::tsf_status_t                  status
);
    import tsf_pkg::*;

    localparam int SLOT_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PT_BITS      = $clog2(MAX_POINTS);
    localparam int ADDR_BITS    = SLOT_BITS + PT_BITS;
    localparam int MEM_DEPTH    = MAX_WINDOW * MAX_POINTS;
    localparam int IDX_EXT_BITS = IDX_BITS + PT_BITS;
    localparam int ACC_BITS     = SAMPLE_BITS + WSUM_BITS;
    localparam int PROD_BITS    = SAMPLE_BITS + WT_BITS;

    // Configuration registers
    filter_mode_t              filter_mode_reg;
    logic [WLEN_CFG_BITS-1:0]  window_length_reg;
    logic [PC_BITS-1:0]        point_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg   <= MODE_PASS;
            window_length_reg <= WINDOW_LENGTH_RST;
            point_count_reg   <= POINT_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FILTER_MODE:   filter_mode_reg   <= filter_mode_t'(cfg_data[MODE_BITS-1:0]);
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WLEN_CFG_BITS-1:0];
                REG_POINT_COUNT:   point_count_reg   <= cfg_data[PC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective window: zero acts as one, saturate at the store depth
    logic [WLEN_BITS-1:0] w_eff;
    always_comb begin
        priority if (window_length_reg == '0)
            w_eff = WLEN_BITS'(1);
        else if (WLEN_BITS'(window_length_reg) > WLEN_BITS'(MAX_WINDOW))
            w_eff = WLEN_BITS'(MAX_WINDOW);
        else
            w_eff = WLEN_BITS'(window_length_reg);
    end

    logic pass;
    logic median;
    assign pass   = (filter_mode_reg == MODE_PASS) || (w_eff == WLEN_BITS'(1));
    assign median = (filter_mode_reg == MODE_MEDIAN);

    // Transaction capture and frame slot ring
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [SLOT_BITS-1:0]   slot_cur_reg;
    logic [SLOT_BITS-1:0]   frame_slot_reg;
    logic [SLOT_BITS-1:0]   frame_slot_inc;
    logic                   advance;

    assign advance = (point_count_reg != '0) &&
                     ((PC_BITS'(s_point_index) + PC_BITS'(1)) == point_count_reg);
    assign frame_slot_inc = (frame_slot_reg == SLOT_BITS'(MAX_WINDOW - 1)) ?
                            '0 : frame_slot_reg + SLOT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_slot_reg <= '0;
        end else if (cmd.op == OP_ACCEPT && advance) begin
            frame_slot_reg <= frame_slot_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ACCEPT) begin
            x_reg        <= SAMPLE_BITS'(s_sample);
            idx_reg      <= s_point_index;
            slot_cur_reg <= frame_slot_reg;
        end
    end

    logic [IDX_EXT_BITS-1:0] idx_ext;
    logic [PT_BITS-1:0]      pt;
    assign idx_ext = IDX_EXT_BITS'(idx_reg);
    assign pt      = idx_ext[PT_BITS-1:0];

    // Clear sweep over the history memory after reset
    logic [ADDR_BITS-1:0] clr_addr_reg;
    logic                 clr_last;
    assign clr_last = (clr_addr_reg == ADDR_BITS'(MEM_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.op == OP_CLEAR && !clr_last) begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
        end
    end

    // Oldest slot of the window and the read slot walker
    logic [SLOT_BITS-1:0] rd_slot_reg;
    logic [SLOT_BITS-1:0] rd_slot_inc;
    logic [WLEN_BITS:0]   slot_w;
    logic [WLEN_BITS:0]   back_w;
    logic [WLEN_BITS:0]   oldest_w;

    assign slot_w   = (WLEN_BITS+1)'(slot_cur_reg);
    assign back_w   = (WLEN_BITS+1)'(w_eff) - (WLEN_BITS+1)'(1);
    assign oldest_w = (slot_w >= back_w) ? slot_w - back_w :
                      slot_w + (WLEN_BITS+1)'(MAX_WINDOW) - back_w;
    assign rd_slot_inc = (rd_slot_reg == SLOT_BITS'(MAX_WINDOW - 1)) ?
                         '0 : rd_slot_reg + SLOT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) rd_slot_reg <= SLOT_BITS'(oldest_w);
        else if (cmd.op == OP_READ) rd_slot_reg <= rd_slot_inc;
    end

    // History memory: one write port, one registered read port
    logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [ADDR_BITS-1:0]   mem_raddr;

    assign mem_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
    assign mem_waddr = (cmd.op == OP_CLEAR) ? clr_addr_reg : {slot_cur_reg, pt};
    assign mem_wdata = (cmd.op == OP_CLEAR) ? '0 : x_reg;
    assign mem_raddr = {rd_slot_reg, pt};

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Window registers, oldest frame first
    logic [SAMPLE_BITS-1:0] win_reg  [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] win_next [MAX_WINDOW];
    logic [SLOT_BITS-1:0]   cnt_idx;
    logic [SLOT_BITS-1:0]   cap_idx;

    assign cnt_idx = SLOT_BITS'(cmd.cnt);
    assign cap_idx = SLOT_BITS'(cmd.cnt - CNT_BITS'(1));

    always_comb begin
        win_next = win_reg;
        unique case (cmd.op)
            OP_WRITE: begin
                // Pad unused slots high so they sort to the top
                for (int k = 0; k < MAX_WINDOW; k++) begin
                    win_next[k] = (WLEN_BITS'(k + 1) == w_eff) ? x_reg : '1;
                end
            end
            OP_READ: begin
                if (cmd.cnt != '0) win_next[cap_idx] = rd_data_reg;
            end
            OP_SORT: begin
                // One odd-even transposition pass
                for (int k = 0; k < MAX_WINDOW - 1; k++) begin
                    if (((k & 1) == int'(cmd.cnt[0])) && (win_reg[k] > win_reg[k+1])) begin
                        win_next[k]   = win_reg[k+1];
                        win_next[k+1] = win_reg[k];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    // Weighted accumulate: Gaussian table or unit weights
    logic [ACC_BITS-1:0]  acc_reg;
    logic [WSUM_BITS-1:0] wsum_reg;
    logic [WLEN_BITS-1:0] half_w;
    logic [WLEN_BITS-1:0] cnt_w;
    logic [WLEN_BITS-1:0] wt_dist;
    logic [WT_BITS-1:0]   weight;
    logic [PROD_BITS-1:0] product;

    assign half_w  = w_eff >> 1;
    assign cnt_w   = WLEN_BITS'(cmd.cnt);
    assign wt_dist = (cnt_w >= half_w) ? cnt_w - half_w : half_w - cnt_w;
    assign weight  = (filter_mode_reg == MODE_GAUSS) ? gauss_weight(wt_dist[2:0]) :
                     WT_BITS'(1);
    assign product = PROD_BITS'(weight) * PROD_BITS'(win_reg[cnt_idx]);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end else if (cmd.op == OP_ACCUM) begin
            acc_reg  <= acc_reg + ACC_BITS'(product);
            wsum_reg <= wsum_reg + WSUM_BITS'(weight);
        end
    end

    // Restoring divider, one quotient bit per step
    logic [WSUM_BITS-1:0]   rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [WSUM_BITS:0]     trial;
    logic [WSUM_BITS:0]     trial_sub;
    logic                   fits;

    assign trial     = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign fits      = (trial >= (WSUM_BITS+1)'(wsum_reg));
    assign trial_sub = trial - (WSUM_BITS+1)'(wsum_reg);

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DIV_LOAD) begin
            rem_reg <= acc_reg[ACC_BITS-1:SAMPLE_BITS];
            quo_reg <= acc_reg[SAMPLE_BITS-1:0];
        end else if (cmd.op == OP_DIV_STEP) begin
            rem_reg <= fits ? WSUM_BITS'(trial_sub) : WSUM_BITS'(trial);
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], fits};
        end
    end

    // Result select and output register
    logic [SAMPLE_BITS-1:0] result;
    logic [SLOT_BITS-1:0]   mid_idx;
    logic                   m_valid_reg;
    logic [OUT_BITS-1:0]    m_filtered_value_reg;
    logic [IDX_BITS-1:0]    m_point_out_reg;

    assign mid_idx = SLOT_BITS'(half_w);

    always_comb begin
        priority if (pass) result = x_reg;
        else if (median)   result = win_reg[mid_idx];
        else               result = quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            m_filtered_value_reg <= OUT_BITS'(result);
            m_point_out_reg      <= idx_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_filtered_value_reg;
    assign m_point_out      = m_point_out_reg;

    // Status back to the controller
    assign status.clr_last = clr_last;
    assign status.pass     = pass;
    assign status.median   = median;
    assign status.w_eff    = w_eff;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

[rtl/temporal_scan_filter.sv]
// Top level of the temporal scan filter: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Ports                                      Direction
// -------   -----------------------------------------  ---------
// input     s_valid s_ready s_sample s_point_index     in
// result    m_valid m_ready m_filtered_value m_point_out out
// config    cfg_valid cfg_ready cfg_index cfg_data     in
//
// Steps per transaction, W = effective window: pass-through writes the history and outputs; median
// W history reads, then MAX_WINDOW odd-even sort passes; Gaussian and mean W reads, then W
// multiply-accumulate steps, then a one-bit-per-cycle restoring divider.
// After reset the history memory is cleared one entry per cycle, all MAX_WINDOW * MAX_POINTS
// entries, with s_ready low; configuration writes are taken at any time.
// A result waits in the output register while the next transaction is processed.
module temporal_scan_filter #(
    parameter int MAX_WINDOW  = tsf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_POINTS  = tsf_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tsf_pkg::SAMPLE_WIDTH-1:0]    s_sample,
    input  logic [tsf_pkg::IDX_BITS-1:0]        s_point_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tsf_pkg::OUT_BITS-1:0]        m_filtered_value,
    output logic [tsf_pkg::IDX_BITS-1:0]        m_point_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tsf_pkg::*;

    tsf_cmd_t    cmd;
    tsf_status_t status;

    assign cfg_ready = 1'b1;

    tsf_ctrl #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tsf_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_sample         (s_sample),
        .s_point_index    (s_point_index),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_filtered_value (m_filtered_value),
        .m_point_out      (m_point_out),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the temporal scan filter.
`timescale 1ns / 1ps
module tb;
    import tsf_pkg::*;

    localparam int NWIN = 7;
    localparam int NPTS = 512;
    localparam int GAP_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic [8:0]  s_point_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_filtered_value;
    logic [8:0]  m_point_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    temporal_scan_filter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_point_index(s_point_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_filtered_value(m_filtered_value), .m_point_out(m_point_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    typedef struct packed {
        logic [15:0] value;
        logic [8:0]  point;
    } filt_result_t;

    typedef struct {
        logic [15:0] sample;
        logic [8:0]  point;
        int          value;   // -1: use the filter model
    } stim_row_t;

    // Filter model state
    logic [15:0]  hist [NWIN*NPTS];
    int           slot;
    filter_mode_t mode_q;
    logic [2:0]   wlen_q;
    logic [9:0]   npts_q;

    filt_result_t pending_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit recv_hold = 0;

    task automatic report(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Compute the filtered value for one sample and advance the scan ring
    function automatic filt_result_t filter_sample(input logic [15:0] x,
                                                   input logic [8:0] idx);
        filt_result_t r;
        logic [15:0] win [NWIN];
        logic [15:0] t;
        longint acc, wsum;
        int w, s, d;
        w = (wlen_q == 0) ? 1 : int'(wlen_q);
        hist[slot*NPTS + idx] = x;
        for (int j = 0; j < w; j++) begin
            s = (slot + NWIN - (w - 1 - j)) % NWIN;
            win[j] = hist[s*NPTS + idx];
        end
        if (mode_q == MODE_PASS || w == 1) begin
            r.value = x;
        end else if (mode_q == MODE_GAUSS) begin
            acc = 0;
            wsum = 0;
            for (int j = 0; j < w; j++) begin
                d = j - w / 2;
                if (d < 0) d = -d;
                acc += longint'(GAUSS_Q15[d]) * win[j];
                wsum += GAUSS_Q15[d];
            end
            r.value = 16'(acc / wsum);
        end else if (mode_q == MODE_MEAN) begin
            acc = 0;
            for (int j = 0; j < w; j++) acc += win[j];
            r.value = 16'(acc / w);
        end else begin
            for (int a = 0; a < w; a++)
                for (int b = 0; b < w - 1 - a; b++)
                    if (win[b] > win[b+1]) begin
                        t = win[b]; win[b] = win[b+1]; win[b+1] = t;
                    end
            r.value = win[w/2];
        end
        r.point = idx;
        if (npts_q != 0 && 10'(idx) + 10'd1 == npts_q) slot = (slot + 1) % NWIN;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FILTER_MODE:   mode_q = filter_mode_t'(data[1:0]);
            REG_WINDOW_LENGTH: wlen_q = data[2:0];
            REG_POINT_COUNT:   npts_q = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int mode, input int wl, input int pc);
        write_reg(REG_FILTER_MODE, 10'(mode));
        write_reg(REG_WINDOW_LENGTH, 10'(wl));
        write_reg(REG_POINT_COUNT, 10'(pc));
    endtask

    // Offer one sample; queue the expected result once it is accepted
    task automatic send_sample(input logic [15:0] x, input logic [8:0] idx,
                               input int want);
        filt_result_t r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_sample <= x;
        s_point_index <= idx;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        r = filter_sample(x, idx);
        if (want >= 0 && r.value != 16'(want)) report("table row", r.value, want);
        pending_q = {pending_q, r};
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (GAP_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn || recv_hold) m_ready <= 1'b0;
        else m_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        filt_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", m_filtered_value, -1);
            end else begin
                e = pending_q.pop_front();
                if (m_filtered_value !== e.value) report("value", m_filtered_value, e.value);
                if (m_point_out !== e.point) report("point", m_point_out, e.point);
            end
        end
    end

    stim_row_t dir_rows [3];

    // Random scan traffic: mostly in-order scans with smooth samples
    task automatic random_phase(input int n);
        int p;
        logic [15:0] x;
        p = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                x = 16'($urandom);
                send_sample(x, 9'($urandom), -1);
            end else begin
                x = ($urandom_range(3) == 0) ? 16'($urandom)
                                              : 16'(1000 + $urandom_range(255));
                send_sample(x, 9'(p), -1);
                p = (p + 1 >= int'(npts_q) || npts_q == 0) ? 0 : p + 1;
            end
        end
    endtask

    initial begin
        int mode, wl, pc;
        for (int i = 0; i < NWIN*NPTS; i++) hist[i] = '0;
        slot = 0;
        mode_q = MODE_PASS;
        wlen_q = WINDOW_LENGTH_RST;
        npts_q = POINT_COUNT_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        recv_idle = 0;

        // Directed: reset pass-through, extremes, then short scans in every mode, median with a zero window
        dir_rows[0] = '{16'hFFFF, 9'd511, 65535};
        dir_rows[1] = '{16'h0000, 9'd0, 0};
        dir_rows[2] = '{16'h5555, 9'd400, 21845};
        foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].point,
                                          dir_rows[i].value);
        drain();
        for (int m = 0; m < 4; m++) begin
            configure(m, (m == 3) ? 0 : 7, 2);
            for (int k = 0; k < 5; k++)
                send_sample((k % 2) ? 16'hFFFF : 16'(k * 4099), 9'(k % 2), -1);
            drain();
        end
        // Out-of-range scan length: slot never advances
        configure(MODE_MEAN, 3, 0);
        send_sample(16'hAAAA, 9'd511, -1);
        send_sample(16'h1234, 9'd256, -1);
        drain();
        configure(MODE_MEDIAN, 4, 512);
        send_sample(16'h00FF, 9'd511, -1);
        drain();

        // Random phases across settings and idling patterns
        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 4) begin send_idle = 30; recv_idle = 83; end
            else if (ph < 8) begin send_idle = 83; recv_idle = 30; end
            else begin send_idle = 0; recv_idle = 0; end
            mode = ph % 4;
            wl = (ph % 3 == 0) ? 7 : $urandom_range(7);
            pc = (ph == 5) ? 1 : (ph == 6) ? 512 : $urandom_range(1, 6);
            configure(mode, wl, pc);
            if (ph == 9) begin
                recv_hold = 1;
                fork
                    begin repeat (400) @(posedge aclk); recv_hold = 0; end
                    random_phase(80);
                join
            end else begin
                random_phase(80);
            end
            drain();
        end

        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    initial begin
        #(20ns * 600000);
        $display("tb: done, errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/tsf_pkg.sv
rtl/tsf_ctrl.sv
rtl/tsf_datapath.sv
rtl/temporal_scan_filter.sv
bench/tb.sv
